### design/cha_pkg.sv
// Package with constants, the arctangent table and types for the compass heading pipeline.
package cha_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ITERATIONS      = 16;
  localparam int TABLE_LEN       = 24;
  localparam int PRESCALE_SHIFT  = 14;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;
  localparam int XY_W  = 33;
  localparam int Z_W   = 36;
  localparam int A_W   = 34;

  localparam int LATENCY = ITERATIONS + 3;

  localparam logic signed [Z_W-1:0] Q30_PI     = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] Q30_TWO_PI = 36'sd6746518852;

  localparam int ROUND_SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam logic [A_W-1:0] ROUND_HALF = A_W'(64'd1 << (ROUND_SHIFT - 1));
  localparam logic [A_W-1:0] HEADING_TOP =
    A_W'(((64'd6746518852 + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT) - 64'd1);

  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef struct packed {
    logic y_zero;
    logic y_pos;
    logic x_neg;
  } cha_flags_t;

endpackage

### design/compass_heading_atan2.sv
// Top level: pipelined CORDIC that turns an X/Y magnetometer reading into a heading.
// A reading passes through the fold register, one CORDIC register per iteration, the angle
// register and the output register; done_o is high while heading_o holds the result.
// Throughput: one transfer per cycle; busy_o stays low, and one CORDIC stage per iteration
// plus a fold stage and two output stages make up the pipeline.
// The receiver cannot stall, so every result is shown on heading_o for one cycle.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
module compass_heading_atan2
  import cha_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [IN_W-1:0]  mag_x_i,
  input  logic signed [IN_W-1:0]  mag_y_i,
  output logic                    done_o,
  output logic        [OUT_W-1:0] heading_o
);

  logic                    vld_q   [ITERATIONS+1];
  logic signed [XY_W-1:0]  x_q     [ITERATIONS+1];
  logic signed [XY_W-1:0]  y_q     [ITERATIONS+1];
  logic signed [Z_W-1:0]   z_q     [ITERATIONS+1];
  cha_flags_t              flags_q [ITERATIONS+1];

  logic                    accept;
  logic signed [XY_W-1:0]  x_ext, y_ext;
  logic signed [XY_W-1:0]  x0_d, y0_d;
  logic signed [Z_W-1:0]   z0_d;
  cha_flags_t              flags0_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    x_ext = XY_W'(mag_x_i) <<< PRESCALE_SHIFT;
    y_ext = XY_W'(mag_y_i) <<< PRESCALE_SHIFT;
    flags0_d.x_neg  = mag_x_i[IN_W-1];
    flags0_d.y_zero = (mag_y_i == '0);
    flags0_d.y_pos  = !mag_y_i[IN_W-1] && !flags0_d.y_zero;
    if (flags0_d.x_neg) begin
      x0_d = -x_ext;
      y0_d = -y_ext;
      z0_d = flags0_d.y_pos ? Q30_PI : -Q30_PI;
    end else begin
      x0_d = x_ext;
      y0_d = y_ext;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]     <= x0_d;
    y_q[0]     <= y0_d;
    z_q[0]     <= z0_d;
    flags_q[0] <= flags0_d;
  end

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
    logic signed [XY_W-1:0] xs, ys, x_d, y_d;
    logic signed [Z_W-1:0]  z_d, step;

    always_comb begin
      xs   = x_q[g] >>> g;
      ys   = y_q[g] >>> g;
      step = Z_W'(signed'({1'b0, ATAN_TABLE[g % TABLE_LEN]}));
      if (y_q[g] > 0) begin
        x_d = x_q[g] + ys;
        y_d = y_q[g] - xs;
        z_d = z_q[g] + step;
      end else begin
        x_d = x_q[g] - ys;
        y_d = y_q[g] + xs;
        z_d = z_q[g] - step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[g+1]     <= x_d;
      y_q[g+1]     <= y_d;
      z_q[g+1]     <= z_d;
      flags_q[g+1] <= flags_q[g];
    end
  end

  logic signed [Z_W-1:0] zf, zc;
  logic        [A_W-1:0] ang_d, ang_q;
  logic        [A_W-1:0] hr;
  logic        [A_W-1:0] heading_d;
  logic        [OUT_W-1:0] heading_q;
  logic                  ang_vld_q, done_q;

  always_comb begin
    zf = z_q[ITERATIONS];
    if (flags_q[ITERATIONS].y_pos) begin
      if (zf < 0) begin
        zc = '0;
      end else if (zf > Q30_PI) begin
        zc = Q30_PI;
      end else begin
        zc = zf;
      end
    end else begin
      if (zf >= 0) begin
        zc = '1;
      end else if (zf < -Q30_PI) begin
        zc = -Q30_PI;
      end else begin
        zc = zf;
      end
    end
    if (zc < 0) begin
      zc = zc + Q30_TWO_PI;
    end
    if (flags_q[ITERATIONS].y_zero) begin
      ang_d = flags_q[ITERATIONS].x_neg ? A_W'(Q30_PI) : '0;
    end else begin
      ang_d = A_W'(zc);
    end
  end

  always_comb begin
    hr = (ang_q + ROUND_HALF) >> ROUND_SHIFT;
    heading_d = (hr > HEADING_TOP) ? HEADING_TOP : hr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      ang_vld_q <= vld_q[ITERATIONS];
      done_q    <= ang_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q     <= ang_d;
    heading_q <= heading_d[OUT_W-1:0];
  end

  assign done_o    = done_q;
  assign heading_o = heading_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LATENCY) done_o)
    else $error("Accepted transfer did not produce a result after the pipeline latency.");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("Result strobe without a matching accepted transfer.");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (A_W'(heading_o) <= HEADING_TOP))
    else $error("Heading exceeds a full turn.");

  a_east : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mag_y_i == '0) && !mag_x_i[IN_W-1]) |-> ##(LATENCY) (heading_o == '0))
    else $error("Reading on the positive X axis did not give a zero heading.");

endmodule

### tb/tb.sv
// Self-checking testbench for the pipelined compass heading block with a CORDIC heading model.
module tb;
  import cha_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 650;

  class heading_scoreboard;
    typedef struct {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic [OUT_W-1:0]       heading;
    } heading_expect_t;

    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    longint          arctan_q30[TABLE_LEN];
    heading_expect_t expected_headings[$];
    int              mismatches;
    int              headings_checked;

    function new();
      arctan_q30 = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
      };
      mismatches       = 0;
      headings_checked = 0;
    endfunction

    function automatic logic [OUT_W-1:0] heading_for(logic signed [IN_W-1:0] mx,
                                                      logic signed [IN_W-1:0] my);
      longint x0, y0, x, y, z, xs, ys, half, top, h;
      int     sh;
      x0   = mx;
      y0   = my;
      sh   = 30 - ANGLE_FRAC_BITS;
      half = 64'sd1 << (sh - 1);
      top  = ((TWO_PI_Q30 + half) >>> sh) - 1;
      if (x0 == 0 && y0 == 0) begin
        return '0;
      end
      if (y0 == 0) begin
        z = (x0 < 0) ? PI_Q30 : 0;
      end else begin
        x = x0 <<< PRESCALE_SHIFT;
        y = y0 <<< PRESCALE_SHIFT;
        z = 0;
        if (x0 < 0) begin
          x = -x;
          y = -y;
          z = (y0 > 0) ? PI_Q30 : -PI_Q30;
        end
        for (int i = 0; i < ITERATIONS && i < TABLE_LEN; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_q30[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_q30[i];
          end
        end
        if (y0 > 0) begin
          if (z < 0) z = 0;
          if (z > PI_Q30) z = PI_Q30;
        end else begin
          if (z >= 0) z = -1;
          if (z < -PI_Q30) z = -PI_Q30;
        end
      end
      if (z < 0) z = z + TWO_PI_Q30;
      h = (z + half) >>> sh;
      if (h > top) h = top;
      return h[OUT_W-1:0];
    endfunction

    function void note_reading(logic signed [IN_W-1:0] mx, logic signed [IN_W-1:0] my);
      heading_expect_t e;
      e.x       = mx;
      e.y       = my;
      e.heading = heading_for(mx, my);
      expected_headings.push_back(e);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_heading(logic [OUT_W-1:0] got);
      heading_expect_t e;
      if (expected_headings.size() == 0) begin
        report_mismatch($sformatf("heading %0d arrived with no reading outstanding", got));
      end else begin
        e = expected_headings.pop_front();
        headings_checked++;
        if (got !== e.heading) begin
          report_mismatch($sformatf("x=%0d y=%0d: heading %0d, expected %0d",
                                    e.x, e.y, got, e.heading));
        end
      end
    endtask

    function int pending();
      return expected_headings.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic signed [IN_W-1:0] mag_x_i = '0;
  logic signed [IN_W-1:0] mag_y_i = '0;
  logic                   busy_o;
  logic                   done_o;
  logic [OUT_W-1:0]       heading_o;

  heading_scoreboard sb = new();
  int cycles;
  int directed_sent;
  int random_sent;
  int idle_cycles_total;

  compass_heading_atan2 dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .mag_x_i  (mag_x_i),
    .mag_y_i  (mag_y_i),
    .done_o   (done_o),
    .heading_o(heading_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d headings outstanding", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      sb.check_heading(heading_o);
    end
  end

  task send_reading(logic signed [IN_W-1:0] mx, logic signed [IN_W-1:0] my);
    @(negedge clk_i);
    start_i = 1'b1;
    mag_x_i = mx;
    mag_y_i = my;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_reading(mx, my);
  endtask

  task hold_off(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      mag_x_i = IN_W'($urandom);
      mag_y_i = IN_W'($urandom);
      idle_cycles_total++;
    end
  endtask

  function automatic logic signed [IN_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  task send_random_reading();
    logic signed [IN_W-1:0] mx;
    logic signed [IN_W-1:0] my;
    mx = IN_W'($urandom);
    my = IN_W'($urandom);
    case ($urandom_range(0, 9))
      4: begin
        mx = IN_W'($signed($urandom_range(0, 15)) - 8);
        my = IN_W'($signed($urandom_range(0, 15)) - 8);
      end
      5: begin
        if ($urandom_range(0, 1)) mx = IN_W'($signed($urandom_range(0, 4)) - 2);
        else my = IN_W'($signed($urandom_range(0, 4)) - 2);
      end
      6: begin
        mx = pick_extreme();
        my = pick_extreme();
      end
      7: begin
        my = $urandom_range(0, 1) ? mx : -mx;
      end
      default: ;
    endcase
    send_reading(mx, my);
    random_sent++;
  endtask

  initial begin
    int burst;
    cycles            = 0;
    directed_sent     = 0;
    random_sent       = 0;
    idle_cycles_total = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Axes, corners, the origin and the readings that sit next to the half-plane seams.
    send_reading(16'sd0, 16'sd0);
    send_reading(16'sd32767, 16'sd0);
    send_reading(-16'sd32768, 16'sd0);
    send_reading(16'sd0, 16'sd32767);
    send_reading(16'sd0, -16'sd32768);
    send_reading(16'sd1, 16'sd0);
    send_reading(-16'sd1, 16'sd0);
    send_reading(16'sd0, 16'sd1);
    send_reading(16'sd0, -16'sd1);
    send_reading(16'sd32767, 16'sd32767);
    send_reading(-16'sd32768, -16'sd32768);
    send_reading(-16'sd32768, 16'sd32767);
    send_reading(16'sd32767, -16'sd32768);
    send_reading(16'sd1, 16'sd1);
    send_reading(-16'sd1, 16'sd1);
    send_reading(-16'sd1, -16'sd1);
    send_reading(16'sd1, -16'sd1);
    send_reading(-16'sd32768, 16'sd1);
    send_reading(-16'sd32768, -16'sd1);
    send_reading(16'sd32767, 16'sd1);
    send_reading(16'sd32767, -16'sd1);
    send_reading(-16'sd21846, 16'sd0);
    directed_sent = 22;
    hold_off(2);

    while (random_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && random_sent < RANDOM_ITEMS) begin
        send_random_reading();
        burst--;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 7));
    end
    hold_off(1);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Covered %0d directed and %0d random readings, %0d headings checked.",
             directed_sent, random_sent, sb.headings_checked);
    $display("Input bursts were broken up by %0d idle cycles in total.", idle_cycles_total);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
design/cha_pkg.sv
design/compass_heading_atan2.sv
tb/tb.sv
